// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the anc controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("%m failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("%m failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== hw/rtl/fxlms_pkg.sv =====
`timescale 1ns / 1ps
package fxlms_pkg;
  localparam int SampleW = 16;
  localparam int WeightW = 32;
  localparam int FiltW = 24;
  localparam int ModelTaps = 5;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 40;

  localparam logic [CfgIdxW-1:0] RegStepSize = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPeriod = 3'd1;
  localparam logic [CfgIdxW-1:0] RegModel11 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegModel12 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegModel21 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegModel22 = 3'd5;

  // control handed from the sequencer to the shared datapath
  typedef struct packed {
    logic clear;
    logic mac;
  } mac_ctl_t;

  function automatic logic signed [WeightW-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[WeightW-1:0];
  endfunction
endpackage

// ===== hw/rtl/distributed_fxlms_anc_controller_top.sv =====
`timescale 1ns / 1ps
// Two-node filtered-x LMS noise canceller. One sample enters per s_axis transfer and yields
// one drive pair on m_axis. Every sample is worked by a sequencer over one shared 32x32
// multiplier, walking the tap memories one entry per cycle in the tap walks for drive,
// update accumulation and weight application. A drive pair waits in its own output
// register, so the next sample is taken while it waits; a finished pair holds the
// sequencer until that register frees. After reset a clearing pass over every tap
// zeroes the memories before the first sample is taken.
module distributed_fxlms_anc_controller_top #(
  parameter int ADAPTIVE_TAPS = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [47:0] s_axis_tdata, // ref_sample, err_mic_one, err_mic_two
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [31:0] m_axis_tdata, // drive_one, drive_two
  input  logic cfg_we,
  input  logic [fxlms_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [fxlms_pkg::CfgDataW-1:0] cfg_data
);
  import fxlms_pkg::*;
`include "assert_macros.svh"
  localparam int AW = $clog2(ADAPTIVE_TAPS);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001, S_IDLE = 10'b0000000010, S_FILT = 10'b0000000100,
    S_DRIVE = 10'b0000001000, S_DRV_END = 10'b0000010000, S_MU = 10'b0000100000,
    S_ACC = 10'b0001000000, S_APPLY = 10'b0010000000, S_NEXT = 10'b0100000000,
    S_OUT = 10'b1000000000
  } state_t;

  state_t state;
  logic [31:0] step_size;
  logic [9:0] exchange_period, period_count;
  logic [39:0] model11, model12, model21, model22;
  logic [AW-1:0] long_pos;
  logic [2:0] short_pos;
  logic signed [15:0] short_hist [ModelTaps];
  logic signed [15:0] e1_s, e2_s;
  logic node;            // 0 node one, 1 node two
  logic exch;
  logic full_to_one, full_to_two;
  logic [AW:0] j;        // walk counter, wider to hold the count
  logic [2:0] k;
  logic [1:0] sub;
  logic signed [15:0] drv1, drv2;
  logic [31:0] out_data;

  // memories
  logic signed [15:0] ref_mem [ADAPTIVE_TAPS];
  logic signed [31:0] w_mem [2][ADAPTIVE_TAPS];
  logic signed [23:0] fr_mem [4][ADAPTIVE_TAPS];  // 11, 21, 22, 12
  logic signed [31:0] own_mem [2][ADAPTIVE_TAPS];
  logic signed [31:0] cross_mem [2][ADAPTIVE_TAPS];
  logic signed [31:0] mb_mem [2][ADAPTIVE_TAPS];    // mailbox to node one, to node two

  logic [AW-1:0] addr_j, addr_r;
  logic [AW:0] addr_sum;
  assign addr_j = j[AW-1:0];
  assign addr_sum = (AW+1)'(addr_j) + (AW+1)'(long_pos);
  assign addr_r = (addr_sum >= (AW+1)'(ADAPTIVE_TAPS)) ?
                  AW'(addr_sum - (AW+1)'(ADAPTIVE_TAPS)) : AW'(addr_sum);

  // shared multiplier
  mac_ctl_t ctl;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod, acc;
  fxlms_mac u_mac (.clk(clk), .ctl(ctl), .a(ma), .b(mb), .prod(prod), .acc(acc));

  logic signed [15:0] rd_ref;
  logic signed [31:0] rd_w, rd_own, rd_cross, rd_mb;
  logic signed [31:0] upd_d1, upd_d2;
  logic signed [23:0] rd_fr;
  logic signed [63:0] mval;
  logic signed [39:0] fsum;
  logic [1:0] fsel;
  logic [39:0] cur_model;
  logic [3:0] ssum;
  logic [2:0] sidx;
  logic signed [7:0] tapv;

  always_comb begin
    case (fsel)
      2'd0: cur_model = model11;
      2'd1: cur_model = model21;
      2'd2: cur_model = model22;
      default: cur_model = model12;
    endcase
    ssum = 4'(short_pos) + 4'(k);
    sidx = (ssum >= 4'(ModelTaps)) ? 3'(ssum - 4'(ModelTaps)) : 3'(ssum);
    tapv = cur_model[k*8 +: 8];
  end

  // pipeline of walk address for writeback (memory read, then the mac's input and product registers)
  logic [AW-1:0] wa_d1, wa_d2, wa_d3;
  logic wv_d1, wv_d2, wv_d3;

  always_ff @(posedge clk) begin
    rd_ref <= ref_mem[addr_r];
    rd_w <= w_mem[node][addr_j];
    rd_own <= own_mem[node][addr_j];
    rd_cross <= cross_mem[node][addr_j];
    rd_mb <= mb_mem[node][addr_j];
    rd_fr <= fr_mem[{node, sub[0]}][addr_r];
    // update entry travels beside its product
    upd_d1 <= sub[0] ? rd_cross : rd_own;
    upd_d2 <= upd_d1;
  end

  // operand select
  always_comb begin
    ctl = '0;
    ma = '0;
    mb = '0;
    case (state)
      S_DRIVE: begin
        ma = rd_w;
        mb = 32'(rd_ref);
        ctl.mac = wv_d2;
      end
      S_MU: begin
        ma = $signed({1'b0, step_size[30:0]});
        mb = 32'(node ? e2_s : e1_s);
      end
      S_ACC: begin
        ma = mval[31:0];
        mb = 32'(rd_fr);
      end
      default: ;
    endcase
    if (state == S_IDLE || state == S_DRV_END) ctl.clear = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= 32'd4295;
      exchange_period <= 10'd30;
      model11 <= '0;
      model12 <= '0;
      model21 <= '0;
      model22 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegStepSize: step_size <= cfg_data[31:0];
        RegPeriod: exchange_period <= cfg_data[9:0];
        RegModel11: model11 <= cfg_data;
        RegModel12: model12 <= cfg_data;
        RegModel21: model21 <= cfg_data;
        RegModel22: model22 <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [63:0] t_full;
  logic signed [63:0] wsum;
  always_comb begin
    t_full = prod >>> 23;
    wsum = 64'(rd_w) + 64'(rd_mb) + 64'(rd_own);
  end

  function automatic logic signed [15:0] sat16(input logic signed [63:0] a);
    logic signed [63:0] v;
    v = (-a) >>> 24;
    if (v > 64'sd32767) return 16'sh7fff;
    else if (v < -64'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      j <= '0;
      k <= '0;
      sub <= '0;
      node <= 1'b0;
      long_pos <= '0;
      short_pos <= '0;
      period_count <= '0;
      full_to_one <= 1'b0;
      full_to_two <= 1'b0;
      m_axis_tvalid <= 1'b0;
      wv_d1 <= 1'b0;
      wv_d2 <= 1'b0;
      wv_d3 <= 1'b0;
      for (int i = 0; i < ModelTaps; i++) short_hist[i] <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) m_axis_tvalid <= 1'b0;
      wv_d1 <= (state == S_DRIVE || state == S_ACC) && (j < (AW+1)'(ADAPTIVE_TAPS));
      wv_d2 <= wv_d1;
      wv_d3 <= wv_d2;
      wa_d1 <= addr_j;
      wa_d2 <= wa_d1;
      wa_d3 <= wa_d2;
      case (state)
        S_CLEAR: begin
          ref_mem[addr_j] <= '0;
          for (int n = 0; n < 2; n++) begin
            w_mem[n][addr_j] <= '0;
            own_mem[n][addr_j] <= '0;
            cross_mem[n][addr_j] <= '0;
            mb_mem[n][addr_j] <= '0;
          end
          for (int n = 0; n < 4; n++) fr_mem[n][addr_j] <= '0;
          if (j == (AW+1)'(ADAPTIVE_TAPS - 1)) begin
            j <= '0;
            state <= S_IDLE;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            e1_s <= s_axis_tdata[31:16];
            e2_s <= s_axis_tdata[47:32];
            ref_mem[long_pos] <= s_axis_tdata[15:0];
            short_hist[short_pos] <= s_axis_tdata[15:0];
            exch <= (period_count == 10'(exchange_period - 10'd1));
            node <= 1'b0;
            j <= '0;
            state <= S_DRIVE;
          end
        end
        S_DRIVE: begin
          // read at j; the mac accumulates the entry after the read and input registers
          if (j < (AW+1)'(ADAPTIVE_TAPS + 3)) j <= j + 1'b1;
          else state <= S_DRV_END;
        end
        S_DRV_END: begin
          if (node) drv2 <= sat16(acc);
          else drv1 <= sat16(acc);
          fsel <= {node, 1'b0};
          k <= '0;
          fsum <= '0;
          sub <= '0;
          state <= S_FILT;
        end
        S_FILT: begin
          // 5 tap filter, one small product per cycle
          if (k == 3'(ModelTaps - 1)) begin
            fr_mem[{node, fsel[0]}][long_pos] <=
              24'((fsum + 40'(short_hist[sidx]) * 40'(tapv)) >>> 2);
            k <= '0;
            fsum <= '0;
            if (fsel[0]) begin
              state <= S_MU;
              j <= '0;
            end
            fsel <= fsel + 1'b1;
          end else begin
            fsum <= fsum + 40'(short_hist[sidx]) * 40'(tapv);
            k <= k + 1'b1;
          end
        end
        S_MU: begin
          // mu*e as signed 64; step_size top bit handled by adding e<<31
          if (j == (AW+1)'(2)) begin
            mval <= (prod + (step_size[31] ? (64'(node ? e2_s : e1_s) <<< 31) : 64'sd0))
                    >>> 16;
            j <= '0;
            sub <= '0;
            state <= S_ACC;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_ACC: begin
          if (wv_d3) begin
            if (sub[0])
              cross_mem[node][wa_d3] <= sat32(64'(upd_d2) + t_full);
            else
              own_mem[node][wa_d3] <= sat32(64'(upd_d2) + t_full);
          end
          if (j < (AW+1)'(ADAPTIVE_TAPS + 3)) j <= j + 1'b1;
          else begin
            j <= '0;
            if (!sub[0]) sub <= 2'd1;
            else begin
              sub <= '0;
              state <= S_APPLY;
              if (exch) begin
                if (node) full_to_one <= 1'b1;
                else full_to_two <= 1'b1;
              end
            end
          end
        end
        S_APPLY: begin
          // pass over taps: move cross to mailbox if exchange, apply mailbox and own update if full
          if (j >= (AW+1)'(1) && j <= (AW+1)'(ADAPTIVE_TAPS)) begin
            if (exch) begin
              mb_mem[~node][wa_d1] <= rd_cross;
              cross_mem[node][wa_d1] <= '0;
            end
            if (node ? full_to_two : full_to_one) begin
              w_mem[node][wa_d1] <= sat32(wsum);
              own_mem[node][wa_d1] <= '0;
            end
          end
          if (j < (AW+1)'(ADAPTIVE_TAPS)) j <= j + 1'b1;
          else begin
            j <= '0;
            if (node) full_to_two <= 1'b0;
            else full_to_one <= 1'b0;
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (!node) begin
            node <= 1'b1;
            state <= S_DRIVE;
          end else begin
            period_count <= exch ? '0 : period_count + 10'd1;
            long_pos <= (long_pos == '0) ? AW'(ADAPTIVE_TAPS - 1) : long_pos - 1'b1;
            short_pos <= (short_pos == 3'd0) ? 3'(ModelTaps - 1) : short_pos - 3'd1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // wait here while the previous pair is still unclaimed
          if (!m_axis_tvalid || m_axis_tready) begin
            out_data <= {drv2, drv1};
            m_axis_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata = out_data;

  `ASSERT_IMPLIES(a_ready_idle, clk, rst, s_axis_tready, state == S_IDLE)
  `ASSERT_NEXT(a_take_starts, clk, rst, s_axis_tvalid && s_axis_tready, state == S_DRIVE)
  `ASSERT_NEXT(a_out_stable, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

// ===== hw/rtl/fxlms_mac.sv =====
`timescale 1ns / 1ps
module fxlms_mac (
  input  logic clk,
  input  fxlms_pkg::mac_ctl_t ctl,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod,
  output logic signed [63:0] acc
);
  import fxlms_pkg::*;
  logic signed [31:0] a_r;
  logic signed [31:0] b_r;
  // one 32x32 multiplier, registered, then accumulate
  always_ff @(posedge clk) begin
    a_r <= a;
    b_r <= b;
    prod <= a_r * b_r;
    if (ctl.clear) acc <= '0;
    else if (ctl.mac) acc <= acc + a_r * b_r;
  end
endmodule
